[hw/rtl/ppi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, codes and helpers of the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    KIND_EMIT  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_BUILD = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT_CHK,
    ST_EMIT_DRAW,
    ST_EMIT_WRITE,
    ST_TICK_RUN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_MOVE,
    ST_BUILD_RD,
    ST_BUILD_CHK,
    ST_BUILD_SUM,
    ST_BUILD_END,
    ST_STATUS
  } state_t;

  // input item
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        range_x;
    logic [30:0]        range_y;
    logic [30:0]        range_z;
    logic [31:0]        color_rgba;
    logic [30:0]        lifetime;
    logic [30:0]        sprite_size;
    logic [6:0]         amount;
    logic [30:0]        step_or_distance;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [30:0]        vertex_size;
    logic [31:0]        vertex_color;
    logic               vertex_valid;
    logic               last;
    logic [6:0]         live_count;
  } out_item_t;

  // one particle record in the pool memory
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] life;
    logic [30:0]        size;
    logic [31:0]        color;
  } entry_t;

  // bounds of one random draw: value = lo + floor(u * span / 2^24)
  typedef struct packed {
    logic signed [32:0] lo;
    logic signed [32:0] span;
  } draw_req_t;

  localparam logic [31:0]        LCG_MUL    = 32'd1664525;
  localparam logic [31:0]        LCG_ADD    = 32'd1013904223;
  localparam logic signed [32:0] HALF_Q16   = 33'sh0_0000_8000;
  localparam int                 DRAW_SHIFT = 24;
  localparam int                 FRAC_BITS  = 16;
  localparam logic [6:0]         RESULT_CAP = 7'd64;
  localparam logic signed [47:0] SAT_MAX    = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_MIN    = -48'sh0000_8000_0000;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ppi_chan_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_chan_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface ppi_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/particle_pool_integrator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_integrator_unit
// Particle pool with emit, Euler tick, vertex build and status over one memory.
// ----------------------------------------------------------------------------
// One item is worked at a time; the next is taken once the last result of
// the current one sits in the output register. Emit makes each particle
// with three dependent random draws of three steps each. Tick streams
// the pool through a read, multiply, add/write pipeline, then scans for
// dead particles from the top, with a refill copy from the top for each
// dead one below it. Build inspects one particle at a time (read, distance
// squares, compare) and stalls only while the output register is full.
// The memory has one read and one write port. No clearing pass runs after
// reset: entries at or above the live count are never read, so the live
// count alone stands in for the cleared life store. The seed is taken only
// while the block is idle.
module particle_pool_integrator_unit
  import ppi_pkg::*;
#(
  parameter int POOL_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  ppi_chan_if.sink  items,
  ppi_chan_if.source vertices,
  ppi_chan_if.sink  seed_cfg
);

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(POOL_DEPTH);

  state_t state, state_next;
  in_item_t cur;
  logic [CW-1:0] alive, idx, scan_k;
  logic [6:0] cnt;
  logic [1:0] comp;
  logic signed [31:0] vel_x, vel_y;
  logic [61:0] dd;

  logic mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  entry_t mem_wdata, mem_rdata;

  logic p1_v, p2_v;
  logic [IW-1:0] p1_idx, p2_idx;
  entry_t p2_e;
  logic signed [63:0] m_x, m_y, m_z;
  entry_t tick_e;

  logic [61:0] sq_x, sq_y, sq_z;
  entry_t b_e, pend;
  logic pend_v;

  out_item_t res, load_data;
  logic res_v, load_res, out_free, in_acc;

  logic draw_start, draw_done;
  draw_req_t draw_req;
  logic signed [31:0] draw_val;

  logic [6:0] limit;
  logic rd_dead, far, sum_ok, tick_more;
  logic [IW-1:0] scan_j, top_j;
  logic signed [32:0] dx, dy, dz, dlim;
  logic [32:0] ax, ay, az;
  logic signed [32:0] sd_s, rx_s, ry_s, rz_s;
  logic [63:0] dsum;

  ppi_store #(.DEPTH(POOL_DEPTH), .IW(IW)) u_store (
    .clk(clk), .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata),
    .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata)
  );

  ppi_draw u_draw (
    .clk(clk), .rst(rst),
    .seed_we(seed_cfg.valid && seed_cfg.ready), .seed(seed_cfg.data),
    .start(draw_start), .req(draw_req), .done(draw_done), .value(draw_val)
  );

  assign seed_cfg.ready = (state == ST_IDLE) && !rst;
  assign vertices.valid = res_v;
  assign vertices.data  = res;

  // handshake and shared helpers
  assign in_acc    = items.valid && items.ready;
  assign out_free  = !res_v || vertices.ready;
  assign limit     = (cur.amount < RESULT_CAP) ? cur.amount : RESULT_CAP;
  assign rd_dead   = (mem_rdata.life <= 0);
  assign tick_more = (idx < alive);
  assign scan_j    = IW'(scan_k - CW'(1));
  assign top_j     = IW'(alive - CW'(1));

  // random draw bounds per axis
  assign sd_s = $signed({2'b00, cur.step_or_distance});
  assign rx_s = $signed({2'b00, cur.range_x});
  assign ry_s = $signed({2'b00, cur.range_y});
  assign rz_s = $signed({2'b00, cur.range_z});
  always_comb begin
    unique case (comp)
      2'd0:    draw_req = '{lo: -rx_s, span: rx_s <<< 1};
      2'd1:    draw_req = '{lo: HALF_Q16, span: ry_s - HALF_Q16};
      default: draw_req = '{lo: -rz_s, span: rz_s <<< 1};
    endcase
  end

  // integrate step on the record leaving the multiply stage
  always_comb begin
    tick_e      = p2_e;
    tick_e.px   = sat32(48'(p2_e.px) + 48'(m_x >>> FRAC_BITS));
    tick_e.py   = sat32(48'(p2_e.py) + 48'(m_y >>> FRAC_BITS));
    tick_e.pz   = sat32(48'(p2_e.pz) + 48'(m_z >>> FRAC_BITS));
    tick_e.life = sat32(48'(p2_e.life) - 48'(sd_s));
  end

  // camera distance of the record just read
  assign dx   = 33'(mem_rdata.px) - 33'(cur.pos_x);
  assign dy   = 33'(mem_rdata.py) - 33'(cur.pos_y);
  assign dz   = 33'(mem_rdata.pz) - 33'(cur.pos_z);
  assign ax   = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay   = dy[32] ? 33'(-dy) : 33'(dy);
  assign az   = dz[32] ? 33'(-dz) : 33'(dz);
  assign dlim = sd_s;
  assign far  = (cur.step_or_distance != '0) &&
                ((ax > 33'(dlim)) || (ay > 33'(dlim)) || (az > 33'(dlim)));
  assign dsum = 64'(sq_x) + 64'(sq_y) + 64'(sq_z);
  assign sum_ok = (cur.step_or_distance == '0) || (dsum <= 64'(dd));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (items.data.kind)
            KIND_EMIT:  state_next = ST_EMIT_CHK;
            KIND_TICK:  state_next = ST_TICK_RUN;
            KIND_BUILD: state_next = ST_BUILD_RD;
            KIND_NONE:  state_next = ST_STATUS;
          endcase
        end
      end
      ST_EMIT_CHK: begin
        state_next = (cnt >= cur.amount || alive >= FULL) ? ST_STATUS : ST_EMIT_DRAW;
      end
      ST_EMIT_DRAW: begin
        if (draw_done && comp == 2'd2) begin
          state_next = ST_EMIT_WRITE;
        end
      end
      ST_EMIT_WRITE: state_next = ST_EMIT_CHK;
      ST_TICK_RUN: begin
        if (!tick_more && !p1_v && !p2_v) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_next = (scan_k == '0) ? ST_STATUS : ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        state_next = (rd_dead && scan_j != top_j) ? ST_SCAN_MOVE : ST_SCAN_RD;
      end
      ST_SCAN_MOVE: state_next = ST_SCAN_RD;
      ST_BUILD_RD: begin
        state_next = (idx >= alive || cnt >= limit) ? ST_BUILD_END : ST_BUILD_CHK;
      end
      ST_BUILD_CHK: state_next = (rd_dead || far) ? ST_BUILD_RD : ST_BUILD_SUM;
      ST_BUILD_SUM: begin
        if (!sum_ok || !pend_v || out_free) begin
          state_next = ST_BUILD_RD;
        end
      end
      ST_BUILD_END, ST_STATUS: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    items.ready = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = idx[IW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = p2_idx;
    mem_wdata   = tick_e;
    draw_start  = 1'b0;
    load_res    = 1'b0;
    load_data   = '0;
    load_data.last       = 1'b1;
    load_data.live_count = 7'(alive);
    unique case (state)
      ST_IDLE: items.ready = !rst;
      ST_EMIT_CHK: draw_start = !(cnt >= cur.amount || alive >= FULL);
      ST_EMIT_DRAW: draw_start = draw_done && comp != 2'd2;
      ST_EMIT_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = alive[IW-1:0];
        mem_wdata = '{px: cur.pos_x, py: cur.pos_y, pz: cur.pos_z,
                      vx: vel_x, vy: vel_y, vz: draw_val,
                      life: $signed({1'b0, cur.lifetime}),
                      size: cur.sprite_size, color: cur.color_rgba};
      end
      ST_TICK_RUN: begin
        mem_re = tick_more;
        mem_we = p2_v;
      end
      ST_SCAN_RD: begin
        mem_re    = (scan_k != '0);
        mem_raddr = scan_j;
      end
      ST_SCAN_CHK: begin
        mem_re    = rd_dead && scan_j != top_j;
        mem_raddr = top_j;
      end
      ST_SCAN_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = scan_j;
        mem_wdata = mem_rdata;
      end
      ST_BUILD_RD: mem_re = !(idx >= alive || cnt >= limit);
      ST_BUILD_SUM: begin
        if (sum_ok && pend_v && out_free) begin
          load_res  = 1'b1;
          load_data = '{vertex_x: pend.px, vertex_y: pend.py, vertex_z: pend.pz,
                        vertex_size: pend.size, vertex_color: pend.color,
                        vertex_valid: 1'b1, last: 1'b0,
                        live_count: 7'(alive)};
        end
      end
      ST_BUILD_END: begin
        load_res = out_free;
        if (pend_v) begin
          load_data = '{vertex_x: pend.px, vertex_y: pend.py, vertex_z: pend.pz,
                        vertex_size: pend.size, vertex_color: pend.color,
                        vertex_valid: 1'b1, last: 1'b1,
                        live_count: 7'(alive)};
        end
      end
      ST_STATUS: load_res = out_free;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alive  <= '0;
      pend_v <= 1'b0;
      p1_v   <= 1'b0;
      p2_v   <= 1'b0;
    end else begin
      p1_v <= (state == ST_TICK_RUN) && tick_more;
      p2_v <= p1_v;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cur    <= items.data;
            idx    <= '0;
            cnt    <= '0;
            pend_v <= 1'b0;
            dd     <= items.data.step_or_distance * items.data.step_or_distance;
          end
        end
        ST_EMIT_CHK: comp <= 2'd0;
        ST_EMIT_DRAW: begin
          if (draw_done) begin
            if (comp == 2'd0) vel_x <= draw_val;
            if (comp == 2'd1) vel_y <= draw_val;
            if (comp != 2'd2) comp <= comp + 2'd1;
          end
        end
        ST_EMIT_WRITE: begin
          alive <= alive + CW'(1);
          cnt   <= cnt + 7'd1;
        end
        ST_TICK_RUN: begin
          scan_k <= alive;
          if (tick_more) idx <= idx + CW'(1);
        end
        ST_SCAN_CHK: begin
          if (rd_dead) alive <= alive - CW'(1);
          if (!(rd_dead && scan_j != top_j)) scan_k <= scan_k - CW'(1);
        end
        ST_SCAN_MOVE: scan_k <= scan_k - CW'(1);
        ST_BUILD_RD: begin
          if (!(idx >= alive || cnt >= limit)) idx <= idx + CW'(1);
        end
        ST_BUILD_CHK: begin
          b_e  <= mem_rdata;
          sq_x <= ax[30:0] * ax[30:0];
          sq_y <= ay[30:0] * ay[30:0];
          sq_z <= az[30:0] * az[30:0];
        end
        ST_BUILD_SUM: begin
          if (sum_ok && (!pend_v || out_free)) begin
            pend   <= b_e;
            pend_v <= 1'b1;
            cnt    <= cnt + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // integrate pipeline: read, multiply, add and write back
  always_ff @(posedge clk) begin
    p1_idx <= idx[IW-1:0];
    p2_idx <= p1_idx;
    p2_e   <= mem_rdata;
    m_x    <= mem_rdata.vx * sd_s;
    m_y    <= mem_rdata.vy * sd_s;
    m_z    <= mem_rdata.vz * sd_s;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (load_res) begin
      res_v <= 1'b1;
      res   <= load_data;
    end else if (vertices.ready) begin
      res_v <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !items.ready)
    else $error("item taken while another is in work");

  a_emit_grows: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_WRITE |=> alive == $past(alive) + CW'(1) && alive <= FULL)
    else $error("emit did not add exactly one particle");

  a_tick_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK_RUN && p2_v) |-> CW'(p2_idx) < alive)
    else $error("integrate write beyond live particles");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load_res |-> out_free)
    else $error("result loaded over one not yet taken");
`endif

endmodule
`default_nettype wire

[hw/rtl/ppi_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_store
// Particle pool memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppi_store
  import ppi_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ppi_draw.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_draw
// Random generator state and a three-step draw unit: generator step,
// scale multiply, offset with clamp.
// ----------------------------------------------------------------------------
module ppi_draw
  import ppi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               seed_we,
  input  logic [31:0]        seed,
  input  logic               start,
  input  draw_req_t          req,
  output logic               done,
  output logic signed [31:0] value
);

  logic [31:0]        rs;
  logic [1:0]         phase;
  logic signed [57:0] prod;
  logic signed [47:0] sum;

  assign sum = 48'(req.lo) + 48'(prod >>> DRAW_SHIFT);

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      rs <= '0;
    end else if (seed_we) begin
      rs <= seed;
    end else if (start) begin
      rs <= rs * LCG_MUL + LCG_ADD;
    end
  end

  // draw sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        phase <= 2'd1;
      end else if (phase == 2'd1) begin
        phase <= 2'd2;
      end else if (phase == 2'd2) begin
        phase <= 2'd0;
        done  <= 1'b1;
      end
    end
  end

  // scale and offset
  always_ff @(posedge clk) begin
    if (phase == 2'd1) begin
      prod <= $signed({1'b0, rs[31:8]}) * req.span;
    end
    if (phase == 2'd2) begin
      value <= sat32(sum);
    end
  end

endmodule
`default_nettype wire
